@@ rtl/tmwd_pkg.sv @@
package tmwd_pkg;

    localparam int unsigned CountW   = 16;
    localparam int unsigned CodeW    = 2;
    localparam int unsigned InBytesW = 8;
    localparam int unsigned OutBytesW = 8;

    localparam logic [CountW-1:0] TimeoutReset = 16'd46079;

    typedef enum logic [CodeW-1:0] {
        CODE_RIGHT  = 2'd0,
        CODE_LEFT   = 2'd1,
        CODE_START  = 2'd2,
        CODE_FINISH = 2'd3
    } t_code;

    typedef enum logic [2:0] {
        PH_WAIT  = 3'd0,
        PH_BAR1  = 3'd1,
        PH_GAP   = 3'd2,
        PH_BAR2  = 3'd3,
        PH_TAIL1 = 3'd4,
        PH_TAIL2 = 3'd5
    } t_phase;

    typedef struct packed {
        logic  first_finish;
        logic  busy_res;
        t_code mark_code;
        logic  mark_valid;
    } t_result;

    // Wide bar: longer than 1.5 times the gap, sum kept in 17 bits.
    function automatic logic is_wide(input logic [CountW-1:0] bar,
                                     input logic [CountW-1:0] gap);
        logic [CountW:0] limit;
        limit = {1'b0, gap} + {2'b00, gap[CountW-1:1]};
        return {1'b0, bar} > limit;
    endfunction

endpackage

@@ rtl/tape_mark_width_decoder.sv @@
// Channel  | Direction | Handshake                   | Payload
// s_axis   | in        | s_axis_tvalid/s_axis_tready | tdata[0] edge_req
// m_axis   | out       | m_axis_tvalid/m_axis_tready | tdata[0] mark_valid, [2:1] mark_code,
//          |           |                             | [3] busy_res, [4] first_finish
// cfg      | in        | i_cfg_valid/o_cfg_ready     | i_cfg_data idle_timeout
//
// One request per clock while results are taken; a request passes the input register, then the result register.
// The decode and the counter update sit between the input register and the result register.
// Synchronous active-low reset clears the sequence state and sets idle_timeout to 46079.
// A stalled result holds the output register; the input register refills in the same cycle
// the result is taken, so s_axis_tready follows m_axis_tready.
// The configuration channel is always ready.
module tape_mark_width_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [tmwd_pkg::InBytesW-1:0]     s_axis_tdata,  // edge_req
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // mark_valid, mark_code, busy_res, first_finish
    output logic [tmwd_pkg::OutBytesW-1:0]    m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tmwd_pkg::CountW-1:0]       i_cfg_data
);

    logic              stage_valid;
    logic              stage_edge;
    logic              advance;
    tmwd_pkg::t_result core_result;
    tmwd_pkg::t_result out_result;

    assign o_cfg_ready = 1'b1;

    tmwd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_edge    (s_axis_tdata[0]),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_edge    (stage_edge)
    );

    tmwd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_step     (advance),
        .i_edge     (stage_edge),
        .o_result   (core_result)
    );

    tmwd_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (stage_valid),
        .i_result  (core_result),
        .o_advance (advance),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (out_result)
    );

    assign m_axis_tdata = {
        {(tmwd_pkg::OutBytesW - $bits(tmwd_pkg::t_result)){1'b0}}, out_result
    };

endmodule

@@ rtl/tmwd_in_reg.sv @@
module tmwd_in_reg (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic i_edge,
    input  logic i_advance,
    output logic o_valid,
    output logic o_edge
);

    logic r_valid;
    logic r_edge;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_edge  = r_edge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_edge <= i_edge;
        end
    end

endmodule

@@ rtl/tmwd_core.sv @@
module tmwd_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tmwd_pkg::CountW-1:0]    i_cfg_data,
    input  logic                           i_step,
    input  logic                           i_edge,
    output tmwd_pkg::t_result              o_result
);

    logic [tmwd_pkg::CountW-1:0] r_timeout, n_timeout;
    logic [tmwd_pkg::CountW-1:0] r_tick, n_tick;
    logic [tmwd_pkg::CountW-1:0] r_first, n_first;
    logic [tmwd_pkg::CountW-1:0] r_gap, n_gap;
    tmwd_pkg::t_phase            r_phase, n_phase;
    logic                        r_busy, n_busy;
    logic                        r_fin_seen, n_fin_seen;
    logic                        cleared;
    logic                        wide1;
    logic                        wide2;
    tmwd_pkg::t_result           res;

    always_comb begin
        n_timeout  = i_cfg_we ? i_cfg_data : r_timeout;
        n_tick     = r_tick;
        n_first    = r_first;
        n_gap      = r_gap;
        n_phase    = r_phase;
        n_busy     = r_busy;
        n_fin_seen = r_fin_seen;
        cleared    = 1'b0;
        wide1      = tmwd_pkg::is_wide(r_first, r_gap);
        wide2      = tmwd_pkg::is_wide(r_tick, r_gap);
        res        = '0;
        res.mark_code = tmwd_pkg::CODE_RIGHT;

        if (i_edge) begin
            n_busy = 1'b1;
            case (r_phase)
                tmwd_pkg::PH_BAR1: begin
                    n_first = r_tick;
                    n_tick  = '0;
                    cleared = 1'b1;
                    n_phase = tmwd_pkg::PH_GAP;
                end
                tmwd_pkg::PH_GAP: begin
                    n_gap   = r_tick;
                    n_tick  = '0;
                    cleared = 1'b1;
                    n_phase = tmwd_pkg::PH_BAR2;
                end
                tmwd_pkg::PH_BAR2: begin
                    n_tick  = '0;
                    cleared = 1'b1;
                    if (wide1 || wide2) begin
                        n_phase        = tmwd_pkg::PH_WAIT;
                        res.mark_valid = 1'b1;
                        n_busy         = 1'b0;
                        if (wide1 && !wide2) begin
                            res.mark_code = tmwd_pkg::CODE_RIGHT;
                        end else if (!wide1 && wide2) begin
                            res.mark_code = tmwd_pkg::CODE_LEFT;
                        end else begin
                            res.mark_code = tmwd_pkg::CODE_START;
                        end
                    end else begin
                        n_phase = tmwd_pkg::PH_TAIL1;
                    end
                end
                tmwd_pkg::PH_TAIL1: begin
                    n_phase = tmwd_pkg::PH_TAIL2;
                end
                tmwd_pkg::PH_TAIL2: begin
                    n_phase          = tmwd_pkg::PH_WAIT;
                    res.mark_valid   = 1'b1;
                    res.mark_code    = tmwd_pkg::CODE_FINISH;
                    n_busy           = 1'b0;
                    res.first_finish = !r_fin_seen;
                    n_fin_seen       = 1'b1;
                end
                default: begin
                    // waiting for the first edge, unused codes act the same
                    n_tick  = '0;
                    cleared = 1'b1;
                    n_phase = tmwd_pkg::PH_BAR1;
                end
            endcase
        end

        // saturate the tick counter
        if (!cleared && (r_tick != '1)) begin
            n_tick = r_tick + 1'b1;
        end

        // abandon a stale sequence
        if (n_tick >= r_timeout) begin
            n_tick  = '0;
            n_phase = tmwd_pkg::PH_WAIT;
            n_busy  = 1'b0;
        end

        res.busy_res = n_busy;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= tmwd_pkg::TimeoutReset;
        end else begin
            r_timeout <= n_timeout;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= '0;
            r_first    <= '0;
            r_gap      <= '0;
            r_phase    <= tmwd_pkg::PH_WAIT;
            r_busy     <= 1'b0;
            r_fin_seen <= 1'b0;
        end else if (i_step) begin
            r_tick     <= n_tick;
            r_first    <= n_first;
            r_gap      <= n_gap;
            r_phase    <= n_phase;
            r_busy     <= n_busy;
            r_fin_seen <= n_fin_seen;
        end
    end

endmodule

@@ rtl/tmwd_out_reg.sv @@
module tmwd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  tmwd_pkg::t_result i_result,
    output logic              o_advance,
    output logic              o_valid,
    input  logic              i_ready,
    output tmwd_pkg::t_result o_result
);

    logic              r_valid;
    tmwd_pkg::t_result r_result;

    // hold the result until the sink takes it
    assign o_advance = i_valid && (!r_valid || i_ready);
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_result <= i_result;
        end
    end

endmodule

@@ rtl/tmwd_checker.sv @@
module tmwd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [tmwd_pkg::OutBytesW-1:0] m_axis_tdata
);

    logic r_fin_seen;
    logic out_beat;

    assign out_beat = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_seen <= 1'b0;
        end else if (out_beat && m_axis_tdata[4]) begin
            r_fin_seen <= 1'b1;
        end
    end

    // a decoded marking always ends the sequence
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[3])
        else $error("marking reported while still busy");

    a_code_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[2:1] == 2'd0)
            && !m_axis_tdata[4])
        else $error("code or first finish without a marking");

    a_first_finish_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[0]
            && (m_axis_tdata[2:1] == tmwd_pkg::CODE_FINISH))
        else $error("first finish flag on a code other than finish");

    a_first_finish_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && r_fin_seen |-> !m_axis_tdata[4])
        else $error("first finish reported twice");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind tape_mark_width_decoder tmwd_checker u_tmwd_checker (.*);

@@ verif/tape_mark_width_decoder_checker.sv @@
module tape_mark_width_decoder_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_valid,
    input  logic                           i_s_ready,
    input  logic [tmwd_pkg::InBytesW-1:0]  i_s_data,   // edge_req
    input  logic                           i_m_valid,
    input  logic                           i_m_ready,
    // mark_valid, mark_code, busy_res, first_finish
    input  logic [tmwd_pkg::OutBytesW-1:0] i_m_data,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [tmwd_pkg::CountW-1:0]    i_cfg_data,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_marks,
    output int                             o_idle_resets
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [tmwd_pkg::CountW-1:0] timeout_q;
    logic [tmwd_pkg::CountW-1:0] ticks_q;
    logic [tmwd_pkg::CountW-1:0] bar1_q;
    logic [tmwd_pkg::CountW-1:0] gap_q;
    tmwd_pkg::t_phase            phase_q;
    logic                        busy_q;
    logic                        finish_seen_q;

    tmwd_pkg::t_result expected_marks[$];

    initial begin
        o_errors      = 0;
        o_pending     = 0;
        o_checked     = 0;
        o_marks       = 0;
        o_idle_resets = 0;
    end

    // Wide when 2*bar > 3*gap, which matches bar > gap + gap/2 rounded down.
    function automatic logic bar_is_wide(input logic [tmwd_pkg::CountW-1:0] bar,
                                         input logic [tmwd_pkg::CountW-1:0] gap);
        logic [tmwd_pkg::CountW+1:0] twice_bar;
        logic [tmwd_pkg::CountW+1:0] thrice_gap;
        twice_bar  = {1'b0, bar, 1'b0};
        thrice_gap = {2'b00, gap} + {1'b0, gap, 1'b0};
        return twice_bar > thrice_gap;
    endfunction

    task automatic decode_tick(input logic toggle, output tmwd_pkg::t_result res);
        logic                        cleared;
        logic                        wide1;
        logic                        wide2;
        logic [tmwd_pkg::CountW-1:0] bar2;
        res     = '0;
        cleared = 1'b0;
        if (toggle) begin
            busy_q = 1'b1;
            case (phase_q)
                tmwd_pkg::PH_BAR1: begin
                    bar1_q  = ticks_q;
                    ticks_q = '0;
                    cleared = 1'b1;
                    phase_q = tmwd_pkg::PH_GAP;
                end
                tmwd_pkg::PH_GAP: begin
                    gap_q   = ticks_q;
                    ticks_q = '0;
                    cleared = 1'b1;
                    phase_q = tmwd_pkg::PH_BAR2;
                end
                tmwd_pkg::PH_BAR2: begin
                    bar2    = ticks_q;
                    wide1   = bar_is_wide(bar1_q, gap_q);
                    wide2   = bar_is_wide(bar2, gap_q);
                    ticks_q = '0;
                    cleared = 1'b1;
                    if (wide1 || wide2) begin
                        phase_q        = tmwd_pkg::PH_WAIT;
                        res.mark_valid = 1'b1;
                        if (wide1 && !wide2) begin
                            res.mark_code = tmwd_pkg::CODE_RIGHT;
                        end else if (!wide1 && wide2) begin
                            res.mark_code = tmwd_pkg::CODE_LEFT;
                        end else begin
                            res.mark_code = tmwd_pkg::CODE_START;
                        end
                        busy_q = 1'b0;
                    end else begin
                        phase_q = tmwd_pkg::PH_TAIL1;
                    end
                end
                tmwd_pkg::PH_TAIL1: begin
                    phase_q = tmwd_pkg::PH_TAIL2;
                end
                tmwd_pkg::PH_TAIL2: begin
                    phase_q          = tmwd_pkg::PH_WAIT;
                    res.mark_valid   = 1'b1;
                    res.mark_code    = tmwd_pkg::CODE_FINISH;
                    busy_q           = 1'b0;
                    res.first_finish = !finish_seen_q;
                    finish_seen_q    = 1'b1;
                end
                default: begin
                    ticks_q = '0;
                    cleared = 1'b1;
                    phase_q = tmwd_pkg::PH_BAR1;
                end
            endcase
        end
        // advance and saturate
        if (!cleared && ticks_q != '1) begin
            ticks_q = ticks_q + 1'b1;
        end
        if (ticks_q >= timeout_q) begin
            ticks_q = '0;
            phase_q = tmwd_pkg::PH_WAIT;
            busy_q  = 1'b0;
            o_idle_resets++;
        end
        res.busy_res = busy_q;
    endtask

    always @(posedge i_clk) begin : watch
        tmwd_pkg::t_result want;
        tmwd_pkg::t_result got;
        logic              bad;
        if (!i_rst_n) begin
            timeout_q     = tmwd_pkg::TimeoutReset;
            ticks_q       = '0;
            bar1_q        = '0;
            gap_q         = '0;
            phase_q       = tmwd_pkg::PH_WAIT;
            busy_q        = 1'b0;
            finish_seen_q = 1'b0;
            expected_marks.delete();
            o_pending     = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                timeout_q = i_cfg_data;
            end
            if (i_s_valid && i_s_ready) begin
                decode_tick(i_s_data[0], want);
                expected_marks.push_back(want);
                if (want.mark_valid) begin
                    o_marks++;
                end
            end
            if (i_m_valid && i_m_ready) begin
                got = i_m_data[4:0];
                o_checked++;
                if (expected_marks.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) begin
                        $display("result %0d with no request pending: data=%02h",
                                 o_checked, i_m_data);
                    end
                end else begin
                    want = expected_marks.pop_front();
                    bad  = (got.mark_valid !== want.mark_valid)
                        || (got.mark_code !== want.mark_code)
                        || (got.busy_res !== want.busy_res)
                        || (got.first_finish !== want.first_finish)
                        || (i_m_data[tmwd_pkg::OutBytesW-1:5] !== '0);
                    if (bad) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display({"result %0d mismatch: expected valid=%0d code=%0d ",
                                      "busy=%0d first=%0d, got valid=%0b code=%0b busy=%0b ",
                                      "first=%0b pad=%0b"},
                                     o_checked, want.mark_valid, want.mark_code,
                                     want.busy_res, want.first_finish, got.mark_valid,
                                     got.mark_code, got.busy_res, got.first_finish,
                                     i_m_data[tmwd_pkg::OutBytesW-1:5]);
                        end
                    end
                end
            end
            o_pending = expected_marks.size();
        end
    end

endmodule

@@ verif/tape_mark_width_decoder_tb.sv @@
module tape_mark_width_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RunLimit = 1_000_000;

    typedef logic [tmwd_pkg::CountW-1:0] t_count;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [tmwd_pkg::InBytesW-1:0]  s_axis_tdata  = '0;   // edge_req
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // mark_valid, mark_code, busy_res, first_finish
    logic [tmwd_pkg::OutBytesW-1:0] m_axis_tdata;
    logic                           i_cfg_valid   = 1'b0;
    logic                           o_cfg_ready;
    t_count                         i_cfg_data    = '0;

    int errors;
    int pending;
    int checked;
    int marks;
    int idle_resets;

    int send_idle_pct = 38;
    int recv_idle_pct = 63;
    int ticks_sent    = 0;
    int edges_sent    = 0;
    int cycle_count   = 0;

    tape_mark_width_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    tape_mark_width_decoder_checker mark_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_valid     (s_axis_tvalid),
        .i_s_ready     (s_axis_tready),
        .i_s_data      (s_axis_tdata),
        .i_m_valid     (m_axis_tvalid),
        .i_m_ready     (m_axis_tready),
        .i_m_data      (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_marks       (marks),
        .o_idle_resets (idle_resets)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RunLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= i_rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // One timer tick, held until the block takes the request.
    task automatic send_tick(input logic toggle);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(tmwd_pkg::InBytesW-1){1'b0}}, toggle};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        ticks_sent++;
        if (toggle) begin
            edges_sent++;
        end
    endtask

    task automatic send_plain(input int count);
        repeat (count) send_tick(1'b0);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_timeout(input t_count value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly complete markings with random widths; some noise and cut-off sequences.
    task automatic play_marking();
        int roll;
        int bar1;
        int gap;
        int bar2;
        roll = $urandom_range(0, 99);
        gap  = $urandom_range(0, 8);
        bar1 = $urandom_range(0, 2 * gap + 3);
        bar2 = $urandom_range(0, 2 * gap + 3);
        if (roll < 12) begin
            repeat ($urandom_range(1, 16)) send_tick($urandom_range(0, 99) < 35);
        end else begin
            send_tick(1'b1);
            send_plain(bar1);
            send_tick(1'b1);
            send_plain(gap);
            send_tick(1'b1);
            if (roll < 20) begin
                return;
            end
            send_plain(bar2);
            send_tick(1'b1);
            // two narrow bars: close with the finish edges
            if (2 * bar1 <= 3 * gap && 2 * bar2 <= 3 * gap) begin
                send_plain($urandom_range(0, 4));
                send_tick(1'b1);
                send_plain($urandom_range(0, 4));
                send_tick(1'b1);
            end
            send_plain($urandom_range(0, 3));
        end
    endtask

    task automatic run_random(input int budget);
        int start;
        start = ticks_sent;
        while (ticks_sent - start < budget) begin
            play_marking();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // wide-narrow, narrow-wide, wide-wide, then two narrow bars and the finish pair
        send_tick(1'b1); send_tick(1'b0); send_tick(1'b1); send_tick(1'b1); send_tick(1'b1);
        send_tick(1'b1); send_tick(1'b1); send_tick(1'b1); send_tick(1'b0); send_tick(1'b1);
        send_tick(1'b1); send_tick(1'b0); send_tick(1'b1); send_tick(1'b1); send_tick(1'b0);
        send_tick(1'b1);
        repeat (6) send_tick(1'b1);

        run_random(250);
        write_timeout(t_count'(7));
        run_random(200);

        wait_drained();
        send_idle_pct = 63;
        recv_idle_pct = 38;
        write_timeout(t_count'(1));
        run_random(150);
        write_timeout('0);
        run_random(100);
        write_timeout(t_count'($urandom_range(10, 40)));
        run_random(250);

        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_timeout('1);
        run_random(300);
        write_timeout(tmwd_pkg::TimeoutReset);
        run_random(350);
        write_timeout(t_count'($urandom_range(2, 30)));
        run_random(300);

        wait_drained();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);

        $display("covered %0d ticks with %0d comparator edges over seven timeout settings",
                 ticks_sent, edges_sent);
        $display("checked %0d results: %0d markings decoded, %0d idle resets, %0d errors",
                 checked, marks, idle_resets, errors);
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
